[design/mseq_pkg.sv]
// Package for the microprogram sequencer: item structs, request, branch
// function and error codes. No dependencies.

package mseq_pkg;

	localparam int unsigned ADDR_W    = 10;
	localparam int unsigned SPEC_W    = 8;
	localparam int unsigned ENTRIES   = 256;

	// request types
	localparam logic [1:0] REQ_STEP   = 2'd0;
	localparam logic [1:0] REQ_INSTR  = 2'd1;
	localparam logic [1:0] REQ_MODE   = 2'd2;
	localparam logic [1:0] REQ_UNARY  = 2'd3;

	// branch functions
	localparam logic [4:0] BR_UNCOND  = 5'd0;
	localparam logic [4:0] BR_GT      = 5'd1;
	localparam logic [4:0] BR_GE      = 5'd2;
	localparam logic [4:0] BR_EQ      = 5'd3;
	localparam logic [4:0] BR_LE      = 5'd4;
	localparam logic [4:0] BR_LT      = 5'd5;
	localparam logic [4:0] BR_NE      = 5'd6;
	localparam logic [4:0] BR_V       = 5'd7;
	localparam logic [4:0] BR_C       = 5'd8;
	localparam logic [4:0] BR_S       = 5'd9;
	localparam logic [4:0] BR_PREFETCH = 5'd10;
	localparam logic [4:0] BR_UNARY   = 5'd11;
	localparam logic [4:0] BR_PC_EVEN = 5'd12;
	localparam logic [4:0] BR_ADDR_DEC = 5'd13;
	localparam logic [4:0] BR_INSTR_DEC = 5'd14;
	localparam logic [4:0] BR_STOP    = 5'd15;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_PREFETCH = 3'd1;
	localparam logic [2:0] ERR_ADDR     = 3'd2;
	localparam logic [2:0] ERR_INSTR    = 3'd3;
	localparam logic [2:0] ERR_SELF     = 3'd4;
	localparam logic [2:0] ERR_FUNC     = 3'd5;

	// status flag bit positions
	localparam int unsigned FLAG_N = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_V = 2;
	localparam int unsigned FLAG_C = 3;
	localparam int unsigned FLAG_S = 4;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [4:0]        branch_func;
		logic [ADDR_W-1:0] true_target;
		logic [ADDR_W-1:0] false_target;
		logic [4:0]        status_flags;
		logic [SPEC_W-1:0] instr_spec;
		logic              pc_low_bit;
		logic              prefetch_clock;
		logic [1:0]        prefetch_value;
		logic              table_valid;
		logic              data_error;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] next_micro_pc;
		logic              finished;
		logic [2:0]        error_code;
		logic              instruction_done;
	} out_item_t;

endpackage

[design/microprogram_sequencer.sv]
// Microprogram sequencer top level: decode jump tables, next-address logic,
// result register. Depends on mseq_pkg.
//
// Takes one item per clock while the output is not stalled. Accepting an
// item loads the input register together with the registered jump table and
// unary flag lookups; when the input register advances, the new micro-PC and
// status are committed and the result register is loaded. The micro-PC,
// finished, fault and prefetch-valid state closes its loop within the
// next-address logic, so sustained rate is one item per cycle as long as
// results are taken. Table write items update the tables at their accept
// edge and are seen by the very next item. Tables come out of reset with
// all entries invalid and unary flags clear; no clearing pass is needed.

module microprogram_sequencer
	import mseq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ADDR_W-1:0]    cfg_data
);

	logic [ADDR_W-1:0] start_line_q;
	logic [ADDR_W-1:0] micro_pc_q;
	logic              done_q;
	logic              fault_q;
	logic              pfv_q;

	logic [ADDR_W-1:0] instr_mem [ENTRIES];
	logic [ADDR_W-1:0] mode_mem  [ENTRIES];
	logic [ENTRIES-1:0] instr_vld_q;
	logic [ENTRIES-1:0] mode_vld_q;
	logic [ENTRIES-1:0] unary_q;

	in_item_t          item_s1;
	logic              vld_s1;
	logic [ADDR_W-1:0] instr_addr_s1;
	logic [ADDR_W-1:0] mode_addr_s1;
	logic              instr_ok_s1;
	logic              mode_ok_s1;
	logic              unary_s1;

	out_item_t         out_q;
	logic              out_valid_q;

	logic              in_acc;
	logic              adv;

	logic [ADDR_W-1:0] pc_d;
	logic              done_d;
	logic              fault_d;
	logic              pfv_d;
	out_item_t         res_d;

	assign cfg_ready = 1'b1;
	assign adv       = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = vld_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_line_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_line_q <= cfg_data;
		end
	end

	// table address memories and registered lookups
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (in_item.req_type == REQ_INSTR) begin
				instr_mem[in_item.instr_spec] <= in_item.true_target;
			end
			if (in_item.req_type == REQ_MODE) begin
				mode_mem[in_item.instr_spec] <= in_item.true_target;
			end
			instr_addr_s1 <= instr_mem[in_item.instr_spec];
			mode_addr_s1  <= mode_mem[in_item.instr_spec];
			instr_ok_s1   <= instr_vld_q[in_item.instr_spec];
			mode_ok_s1    <= mode_vld_q[in_item.instr_spec];
			unary_s1      <= unary_q[in_item.instr_spec];
			item_s1       <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr_vld_q <= '0;
			mode_vld_q  <= '0;
			unary_q     <= '0;
		end else if (in_acc) begin
			case (in_item.req_type)
				REQ_INSTR: instr_vld_q[in_item.instr_spec] <= in_item.table_valid;
				REQ_MODE:  mode_vld_q[in_item.instr_spec]  <= in_item.table_valid;
				REQ_UNARY: unary_q[in_item.instr_spec]     <= in_item.table_valid;
				default: ;
			endcase
		end
	end

	// next-address logic
	always_comb begin
		logic [ADDR_W-1:0] nxt;
		logic              cond;
		logic              is_cond;
		logic [2:0]        err;
		logic [4:0]        fl;

		nxt     = micro_pc_q;
		cond    = 1'b0;
		is_cond = 1'b1;
		err     = ERR_NONE;
		fl      = item_s1.status_flags;
		pc_d    = micro_pc_q;
		done_d  = done_q;
		fault_d = fault_q;
		pfv_d   = pfv_q;
		res_d   = '0;

		if (item_s1.req_type == REQ_STEP) begin
			if (item_s1.prefetch_clock) begin
				if (item_s1.prefetch_value[1]) begin
					err     = ERR_PREFETCH;
					fault_d = 1'b1;
				end else begin
					pfv_d = item_s1.prefetch_value[0];
				end
			end

			if (!done_q) begin
				if (fault_d || item_s1.data_error) begin
					done_d = 1'b1;
				end
				case (item_s1.branch_func)
					BR_UNCOND: begin
						is_cond = 1'b0;
						nxt     = item_s1.true_target;
					end
					BR_GT:       cond = !fl[FLAG_N] && !fl[FLAG_Z];
					BR_GE:       cond = !fl[FLAG_N];
					BR_EQ:       cond = fl[FLAG_Z];
					BR_LE:       cond = fl[FLAG_N] || fl[FLAG_Z];
					BR_LT:       cond = fl[FLAG_N];
					BR_NE:       cond = !fl[FLAG_Z];
					BR_V:        cond = fl[FLAG_V];
					BR_C:        cond = fl[FLAG_C];
					BR_S:        cond = fl[FLAG_S];
					BR_PREFETCH: cond = pfv_d;
					BR_UNARY:    cond = unary_s1;
					BR_PC_EVEN:  cond = !item_s1.pc_low_bit;
					BR_ADDR_DEC: begin
						is_cond = 1'b0;
						if (mode_ok_s1) begin
							nxt = mode_addr_s1;
						end else begin
							done_d  = 1'b1;
							fault_d = 1'b1;
							err     = ERR_ADDR;
						end
					end
					BR_INSTR_DEC: begin
						is_cond = 1'b0;
						if (instr_ok_s1) begin
							nxt = instr_addr_s1;
						end else begin
							done_d  = 1'b1;
							fault_d = 1'b1;
							err     = ERR_INSTR;
						end
					end
					BR_STOP: begin
						is_cond = 1'b0;
						done_d  = 1'b1;
					end
					default: begin
						is_cond = 1'b0;
						done_d  = 1'b1;
						fault_d = 1'b1;
						err     = ERR_FUNC;
					end
				endcase
				if (is_cond) begin
					nxt = cond ? item_s1.true_target : item_s1.false_target;
				end

				if (fault_d) begin
					done_d = 1'b1;
				end else if (nxt == micro_pc_q && item_s1.branch_func != BR_STOP) begin
					done_d  = 1'b1;
					fault_d = 1'b1;
					err     = ERR_SELF;
				end else begin
					pc_d = nxt;
				end
			end
			res_d.instruction_done = (pc_d == start_line_q) || done_d;
		end

		res_d.next_micro_pc = pc_d;
		res_d.finished      = done_d;
		res_d.error_code    = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			micro_pc_q  <= '0;
			done_q      <= 1'b0;
			fault_q     <= 1'b0;
			pfv_q       <= 1'b0;
		end else begin
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				micro_pc_q  <= pc_d;
				done_q      <= done_d;
				fault_q     <= fault_d;
				pfv_q       <= pfv_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> done_q)
		else $error("finished flag cleared");
	assert property (@(posedge clk) disable iff (!arst_n) fault_q |-> done_q)
		else $error("control fault without finished");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.error_code != ERR_NONE |-> out_q.finished)
		else $error("error reported without finished");
	assert property (@(posedge clk) disable iff (!arst_n) !adv |=> $stable(micro_pc_q))
		else $error("micro pc moved without an item");
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> vld_s1)
		else $error("stall with empty input register");
`endif

endmodule

[tb/microprogram_sequencer_tb.sv]
// Testbench for microprogram_sequencer: directed and random item streams under
// several idle and stall patterns, checked against an in-bench next-address model.
// Depends on mseq_pkg and the microprogram_sequencer RTL.

module microprogram_sequencer_tb;
	import mseq_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

	typedef enum int {
		END_STOP, END_DATA_ERR, END_PREFETCH, END_MODE, END_INSTR, END_SELF, END_FUNC
	} end_kind_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_item_t          in_item;
	logic              out_valid;
	logic              out_stall;
	out_item_t         out_item;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [ADDR_W-1:0] cfg_data;

	// sequencer model state
	logic [ADDR_W-1:0] start_addr;
	logic [ADDR_W-1:0] cur_upc;
	logic              fin_flag;
	logic              fault_flag;
	logic              pf_valid;
	logic [ADDR_W:0]   instr_tbl [ENTRIES];
	logic [ADDR_W:0]   mode_tbl [ENTRIES];
	logic              unary_tbl [ENTRIES];

	out_item_t pending_results [$];
	out_item_t want;
	int        fail_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        hold_left = 0;

	microprogram_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stall, or a long hold-off when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result item with no expected item waiting");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_item.next_micro_pc !== want.next_micro_pc) begin
					$error("next_micro_pc: expected %0d, got %0d",
						want.next_micro_pc, out_item.next_micro_pc);
					fail_count++;
				end
				if (out_item.finished !== want.finished) begin
					$error("finished: expected %0d, got %0d",
						want.finished, out_item.finished);
					fail_count++;
				end
				if (out_item.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d",
						want.error_code, out_item.error_code);
					fail_count++;
				end
				if (out_item.instruction_done !== want.instruction_done) begin
					$error("instruction_done: expected %0d, got %0d",
						want.instruction_done, out_item.instruction_done);
					fail_count++;
				end
			end
		end
	end

	task automatic advance_sequencer(input in_item_t it, output out_item_t res);
		logic [ADDR_W-1:0] nxt;
		logic              take;
		logic              is_cond;
		logic [2:0]        err;
		logic              idone;
		logic              n, z, v, c, s;
		err = ERR_NONE;
		idone = 1'b0;
		case (it.req_type)
			REQ_INSTR: instr_tbl[it.instr_spec] = {it.table_valid, it.true_target};
			REQ_MODE:  mode_tbl[it.instr_spec] = {it.table_valid, it.true_target};
			REQ_UNARY: unary_tbl[it.instr_spec] = it.table_valid;
			default: begin
				n = it.status_flags[FLAG_N];
				z = it.status_flags[FLAG_Z];
				v = it.status_flags[FLAG_V];
				c = it.status_flags[FLAG_C];
				s = it.status_flags[FLAG_S];
				nxt = cur_upc;
				take = 1'b0;
				is_cond = 1'b1;
				if (it.prefetch_clock) begin
					if (it.prefetch_value[1]) begin
						err = ERR_PREFETCH;
						fault_flag = 1'b1;
					end else begin
						pf_valid = it.prefetch_value[0];
					end
				end
				if (!fin_flag) begin
					if (fault_flag || it.data_error)
						fin_flag = 1'b1;
					case (it.branch_func)
						BR_UNCOND: begin
							is_cond = 1'b0;
							nxt = it.true_target;
						end
						BR_GT:       take = !n && !z;
						BR_GE:       take = !n;
						BR_EQ:       take = z;
						BR_LE:       take = n || z;
						BR_LT:       take = n;
						BR_NE:       take = !z;
						BR_V:        take = v;
						BR_C:        take = c;
						BR_S:        take = s;
						BR_PREFETCH: take = pf_valid;
						BR_UNARY:    take = unary_tbl[it.instr_spec];
						BR_PC_EVEN:  take = !it.pc_low_bit;
						BR_ADDR_DEC: begin
							is_cond = 1'b0;
							if (mode_tbl[it.instr_spec][ADDR_W]) begin
								nxt = mode_tbl[it.instr_spec][ADDR_W-1:0];
							end else begin
								fin_flag = 1'b1;
								fault_flag = 1'b1;
								err = ERR_ADDR;
							end
						end
						BR_INSTR_DEC: begin
							is_cond = 1'b0;
							if (instr_tbl[it.instr_spec][ADDR_W]) begin
								nxt = instr_tbl[it.instr_spec][ADDR_W-1:0];
							end else begin
								fin_flag = 1'b1;
								fault_flag = 1'b1;
								err = ERR_INSTR;
							end
						end
						BR_STOP: begin
							is_cond = 1'b0;
							fin_flag = 1'b1;
						end
						default: begin
							is_cond = 1'b0;
							fin_flag = 1'b1;
							fault_flag = 1'b1;
							err = ERR_FUNC;
						end
					endcase
					if (is_cond)
						nxt = take ? it.true_target : it.false_target;
					if (fault_flag) begin
						fin_flag = 1'b1;
					end else if (nxt == cur_upc && it.branch_func != BR_STOP) begin
						fin_flag = 1'b1;
						fault_flag = 1'b1;
						err = ERR_SELF;
					end else begin
						cur_upc = nxt;
					end
				end
				idone = (cur_upc == start_addr) || fin_flag;
			end
		endcase
		res.next_micro_pc = cur_upc;
		res.finished = fin_flag;
		res.error_code = err;
		res.instruction_done = idone;
	endtask

	function automatic logic [ADDR_W-1:0] off_pc(input logic [ADDR_W-1:0] t);
		return (t == cur_upc) ? t + ADDR_W'(1) : t;
	endfunction

	// decode lookup that neither faults nor branches to itself
	function automatic logic decode_ok(input logic [4:0] f, input logic [SPEC_W-1:0] spec);
		if (f == BR_ADDR_DEC)
			return mode_tbl[spec][ADDR_W] && mode_tbl[spec][ADDR_W-1:0] != cur_upc;
		if (f == BR_INSTR_DEC)
			return instr_tbl[spec][ADDR_W] && instr_tbl[spec][ADDR_W-1:0] != cur_upc;
		return 1'b1;
	endfunction

	function automatic logic [SPEC_W-1:0] pick_spec();
		if ($urandom_range(0, 3) == 0)
			return SPEC_W'($urandom_range(0, 255));
		return SPEC_W'($urandom_range(0, 15));
	endfunction

	function automatic in_item_t random_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t table_item(input logic [1:0] req, input logic [SPEC_W-1:0] spec,
			input logic [ADDR_W-1:0] addr, input logic valid);
		in_item_t it;
		it = random_item();
		it.req_type = req;
		it.instr_spec = spec;
		it.true_target = addr;
		it.table_valid = valid;
		return it;
	endfunction

	// item that keeps the sequencer running: no fault, no stop, no self-branch
	function automatic in_item_t run_item();
		in_item_t it;
		int tries;
		it = random_item();
		it.instr_spec = pick_spec();
		if ($urandom_range(0, 3) == 0) begin
			it.req_type = 2'($urandom_range(REQ_INSTR, REQ_UNARY));
			it.table_valid = ($urandom_range(0, 3) != 0);
			return it;
		end
		it.req_type = REQ_STEP;
		it.data_error = 1'b0;
		if (it.prefetch_clock)
			it.prefetch_value[1] = 1'b0;
		it.branch_func = 5'($urandom_range(BR_UNCOND, BR_INSTR_DEC));
		if ($urandom_range(0, 7) == 0)
			it.true_target = start_addr;
		if ($urandom_range(0, 7) == 0)
			it.false_target = start_addr;
		it.true_target = off_pc(it.true_target);
		it.false_target = off_pc(it.false_target);
		tries = 0;
		while (!decode_ok(it.branch_func, it.instr_spec) && tries < 8) begin
			it.instr_spec = pick_spec();
			tries++;
		end
		if (!decode_ok(it.branch_func, it.instr_spec))
			it.branch_func = BR_UNCOND;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		out_item_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item = it;
		do @(posedge clk); while (in_stall);
		advance_sequencer(it, res);
		pending_results.push_back(res);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_start_line(input logic [ADDR_W-1:0] v);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		start_addr = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(input int n, input int send_idle, input int recv_stall);
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		repeat (n) send_item(run_item());
	endtask

	task automatic test_directed();
		in_item_t it;
		set_start_line('0);
		send_item(table_item(REQ_INSTR, 8'h00, ADDR_MAX, 1'b1));
		send_item(table_item(REQ_INSTR, 8'hff, '0, 1'b1));
		send_item(table_item(REQ_MODE, 8'h00, 10'd512, 1'b1));
		send_item(table_item(REQ_MODE, 8'hff, 10'd1, 1'b1));
		send_item(table_item(REQ_UNARY, 8'hff, '0, 1'b1));
		send_item(table_item(REQ_UNARY, 8'h00, ADDR_MAX, 1'b0));
		send_item(table_item(REQ_INSTR, 8'h80, 10'd5, 1'b0));
		for (int f = 0; f <= int'(BR_INSTR_DEC); f++) begin
			it = '0;
			it.req_type = REQ_STEP;
			it.branch_func = 5'(f);
			it.true_target = off_pc(f[0] ? ADDR_MAX : '0);
			it.false_target = off_pc(f[0] ? '0 : ADDR_MAX);
			it.status_flags = f[1] ? 5'h1f : 5'h00;
			it.instr_spec = f[0] ? 8'hff : 8'h00;
			if (!decode_ok(it.branch_func, it.instr_spec))
				it.instr_spec = ~it.instr_spec;
			it.pc_low_bit = f[2];
			it.prefetch_clock = f[0];
			it.prefetch_value = {1'b0, f[1]};
			it.table_valid = f[3];
			send_item(it);
		end
	endtask

	task automatic test_no_idle();
		set_start_line(ADDR_MAX);
		run_phase(250, 0, 0);
	endtask

	task automatic test_sender_idle();
		set_start_line(ADDR_W'($urandom_range(0, 1023)));
		run_phase(250, 80, 0);
	endtask

	task automatic test_receiver_stall();
		set_start_line(ADDR_W'($urandom_range(0, 1023)));
		run_phase(250, 0, 80);
	endtask

	task automatic test_both_idle();
		set_start_line(ADDR_W'($urandom_range(0, 1023)));
		run_phase(250, 6, 6);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		repeat (40) send_item(run_item());
	endtask

	// one terminating step, then noise on the finished sequencer
	task automatic test_termination();
		in_item_t it;
		end_kind_t kind;
		send_idle_pct = 20;
		recv_stall_pct = 20;
		kind = end_kind_t'($urandom_range(END_STOP, END_FUNC));
		do it = run_item(); while (it.req_type != REQ_STEP);
		case (kind)
			END_STOP:     it.branch_func = BR_STOP;
			END_DATA_ERR: it.data_error = 1'b1;
			END_PREFETCH: begin
				it.prefetch_clock = 1'b1;
				it.prefetch_value = 2'($urandom_range(2, 3));
			end
			END_MODE: begin
				send_item(table_item(REQ_MODE, it.instr_spec,
					ADDR_W'($urandom_range(0, 1023)), 1'b0));
				it.branch_func = BR_ADDR_DEC;
			end
			END_INSTR: begin
				send_item(table_item(REQ_INSTR, it.instr_spec,
					ADDR_W'($urandom_range(0, 1023)), 1'b0));
				it.branch_func = BR_INSTR_DEC;
			end
			END_SELF: begin
				it.branch_func = BR_UNCOND;
				it.true_target = cur_upc;
			end
			default: it.branch_func = 5'($urandom_range(16, 31));
		endcase
		send_item(it);
		repeat (60) send_item(random_item());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		start_addr = '0;
		cur_upc = '0;
		fin_flag = 1'b0;
		fault_flag = 1'b0;
		pf_valid = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			instr_tbl[i] = '0;
			mode_tbl[i] = '0;
			unary_tbl[i] = 1'b0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		test_termination();

		wait_idle();
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[files.f]
design/mseq_pkg.sv
design/microprogram_sequencer.sv
tb/microprogram_sequencer_tb.sv
